// ----- design/stb_pkg.sv -----
// ----------------------------------------------------------------------------
// stb_pkg: shared definitions for the timer bank
// command codes, default sizes and the cell command/status structs
// ----------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

  localparam int NUM_TIMERS_DEF  = 32;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int FUNC_W          = 3;
  localparam int ID_W            = 5;
  localparam int MASK_W          = 32;

  // command codes
  localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ALLOC  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_START  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_STOP   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RESUME = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RESET  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd6;

  // command broadcast to every cell
  typedef struct packed {
    logic              vld;
    logic [FUNC_W-1:0] func;
    logic              mode;
    logic              notify;
  } cmd_t;

  // status returned by each cell
  typedef struct packed {
    logic fire;
    logic zero;
    logic run;
  } cell_sts_t;

endpackage

`default_nettype wire

// ----- design/stb_cell.sv -----
// ----------------------------------------------------------------------------
// stb_cell: one countdown timer of the bank
// holds one timer's state, updates on the sweep token and on addressed commands, passes the token on
// ----------------------------------------------------------------------------
`default_nettype none

module stb_cell #(
  parameter int IDX         = 0,
  parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire stb_pkg::cmd_t          cmd_i,
  input  wire logic [COUNT_WIDTH-1:0] period_i,
  input  wire logic                   hit_i,
  input  wire logic                   alloc_i,
  input  wire logic                   tok_i,
  output      logic                   tok_o,
  output      stb_pkg::cell_sts_t     sts_o
);
  import stb_pkg::*;

  localparam bit IS_USER = (IDX > 0);
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  logic [COUNT_WIDTH-1:0] per_r, per_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic mode_r, mode_nxt;
  logic run_r, run_nxt;
  logic exp_r, exp_nxt;
  logic ntf_r, ntf_nxt;
  logic tok_r;
  logic fire;

  always_comb begin
    per_nxt  = per_r;
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    run_nxt  = run_r;
    exp_nxt  = exp_r;
    ntf_nxt  = ntf_r;
    fire     = 1'b0;
    if (tok_r && alloc_i) begin
      if (run_r && !exp_r && (cnt_r != '0)) begin
        cnt_nxt = cnt_r - CNT_ONE;
        if (cnt_r == CNT_ONE) begin
          fire    = ntf_r;
          exp_nxt = 1'b1;
          if (!mode_r) run_nxt = 1'b0;
        end
      end else if (run_r && exp_r && mode_r) begin
        cnt_nxt = per_r;
        exp_nxt = 1'b0;
      end
    end else if (cmd_i.vld && hit_i) begin
      case (cmd_i.func)
        FN_START: begin
          per_nxt  = period_i;
          cnt_nxt  = period_i;
          mode_nxt = cmd_i.mode;
          ntf_nxt  = cmd_i.notify;
          run_nxt  = 1'b1;
          exp_nxt  = 1'b0;
        end
        FN_STOP: begin
          if (IS_USER) run_nxt = 1'b0;
        end
        FN_RESUME: begin
          if (IS_USER) run_nxt = 1'b1;
        end
        FN_RESET: begin
          if (IS_USER) begin
            cnt_nxt = per_r;
            exp_nxt = 1'b0;
            run_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_r  <= '0;
      cnt_r  <= '0;
      mode_r <= 1'b0;
      run_r  <= 1'b0;
      exp_r  <= 1'b0;
      ntf_r  <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      per_r  <= per_nxt;
      cnt_r  <= cnt_nxt;
      mode_r <= mode_nxt;
      run_r  <= run_nxt;
      exp_r  <= exp_nxt;
      ntf_r  <= ntf_nxt;
      tok_r  <= tok_i;
    end
  end

  assign tok_o      = tok_r;
  assign sts_o.fire = fire;
  assign sts_o.zero = (cnt_r == '0);
  assign sts_o.run  = run_r;

endmodule

`default_nettype wire

// ----- design/software_timer_bank_top.sv -----
// ----------------------------------------------------------------------------
// software_timer_bank_top: bank of countdown timers driven by commands
// allocate, start, stop, resume, reset and query are answered in the cycle after they are accepted;
// a tick sweeps a token down the row of timer cells
// ----------------------------------------------------------------------------
// the tick result is registered once the token has walked through all the cells
// throughput: one command per cycle while busy is low; no new tick until the sweep ends, busy high
// busy is high only during a tick sweep; results cannot be stalled
// reset (rst_n low, synchronous) clears all timers and leaves only id 0 allocated
`default_nettype none

module software_timer_bank_top #(
  parameter int NUM_TIMERS  = stb_pkg::NUM_TIMERS_DEF,
  parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [stb_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [stb_pkg::ID_W-1:0]    in_timer_id,
  input  wire logic [31:0]                 in_period_ticks,
  input  wire logic                        in_timer_mode,
  input  wire logic                        in_notify_enable,
  // result channel
  output      logic                        out_strobe,
  output      logic                        out_accepted,
  output      logic [stb_pkg::ID_W-1:0]    out_new_id,
  output      logic                        out_count_zero,
  output      logic                        out_is_paused,
  output      logic [stb_pkg::MASK_W-1:0]  out_fired_mask
);
  import stb_pkg::*;

  // allocation counter holds 1..NUM_TIMERS
  localparam int AW = $clog2(NUM_TIMERS + 1);

  logic          busy_r, busy_nxt;
  logic [AW-1:0] alloc_cnt_r, alloc_cnt_nxt;
  logic [NUM_TIMERS-1:0] fired_acc_r, fired_acc_nxt;

  logic                strobe_r;
  logic                acc_r, acc_nxt;
  logic [ID_W-1:0]     nid_r, nid_nxt;
  logic                zero_r, zero_nxt;
  logic                paused_r, paused_nxt;
  logic [MASK_W-1:0]   mask_r, mask_nxt;

  // request decode
  logic tick_acc;
  logic cmd_acc;
  assign tick_acc = start && !busy_r && (in_func == FN_TICK);
  assign cmd_acc  = start && !busy_r && (in_func != FN_TICK);

  // period kept to the counter width
  logic [63:0]            per64;
  logic [COUNT_WIDTH-1:0] period;
  assign per64  = {32'b0, in_period_ticks};
  assign period = per64[COUNT_WIDTH-1:0];

  // command broadcast to the cells
  cmd_t cmd;
  assign cmd.vld    = cmd_acc;
  assign cmd.func   = in_func;
  assign cmd.mode   = in_timer_mode;
  assign cmd.notify = in_notify_enable;

  // token chain and per-cell status
  logic [NUM_TIMERS:0]   tok_w;
  logic [NUM_TIMERS-1:0] hit_vec, alloc_vec, fire_vec, zero_vec, run_vec;
  cell_sts_t             sts [NUM_TIMERS];

  assign tok_w[0] = tick_acc;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    // cell g is allocated while the counter is above its index
    assign alloc_vec[g] = (alloc_cnt_r > AW'(g));
    assign hit_vec[g]   = alloc_vec[g] && (32'(in_timer_id) == 32'(g));

    stb_cell #(
      .IDX         (g),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd_i    (cmd),
      .period_i (period),
      .hit_i    (hit_vec[g]),
      .alloc_i  (alloc_vec[g]),
      .tok_i    (tok_w[g]),
      .tok_o    (tok_w[g+1]),
      .sts_o    (sts[g])
    );

    assign fire_vec[g] = sts[g].fire;
    assign zero_vec[g] = sts[g].zero;
    assign run_vec[g]  = sts[g].run;
  end

  // token leaving the last cell ends the sweep
  logic sweep_done;
  assign sweep_done = tok_w[NUM_TIMERS];

  // fired bits gathered while the token walks; only the low 32 timers show
  logic [NUM_TIMERS-1:0] fired_all;
  logic [63:0]           fired64;
  assign fired_all = fired_acc_r | fire_vec;
  assign fired64   = 64'(fired_all);

  // known id: addressed timer exists and is allocated
  logic        known;
  logic        user_id;
  logic [63:0] alloc64;
  assign known   = |hit_vec;
  assign user_id = known && (in_timer_id != '0);
  assign alloc64 = 64'(alloc_cnt_r);

  always_comb begin
    busy_nxt      = busy_r;
    alloc_cnt_nxt = alloc_cnt_r;
    fired_acc_nxt = tick_acc ? '0 : fired_all;
    acc_nxt       = acc_r;
    nid_nxt       = nid_r;
    zero_nxt      = zero_r;
    paused_nxt    = paused_r;
    mask_nxt      = mask_r;

    if (tick_acc)   busy_nxt = 1'b1;
    if (sweep_done) busy_nxt = 1'b0;

    if (sweep_done) begin
      // tick result
      acc_nxt    = 1'b1;
      nid_nxt    = '0;
      zero_nxt   = 1'b0;
      paused_nxt = 1'b0;
      mask_nxt   = fired64[MASK_W-1:0];
    end else if (cmd_acc) begin
      acc_nxt    = 1'b0;
      nid_nxt    = '0;
      zero_nxt   = 1'b0;
      paused_nxt = 1'b0;
      mask_nxt   = '0;
      case (in_func)
        FN_ALLOC: begin
          // bank full gives a rejected request
          if (alloc_cnt_r < AW'(NUM_TIMERS)) begin
            acc_nxt       = 1'b1;
            nid_nxt       = alloc64[ID_W-1:0];
            alloc_cnt_nxt = alloc_cnt_r + AW'(1);
          end
        end
        FN_START: begin
          acc_nxt = known;
        end
        FN_STOP, FN_RESUME, FN_RESET: begin
          // reserved id zero is refused here
          acc_nxt = user_id;
        end
        FN_QUERY: begin
          acc_nxt    = known;
          zero_nxt   = |(hit_vec & zero_vec);
          paused_nxt = |(hit_vec & ~run_vec);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      alloc_cnt_r <= AW'(1);
      strobe_r    <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      alloc_cnt_r <= alloc_cnt_nxt;
      strobe_r    <= cmd_acc || sweep_done;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    fired_acc_r <= fired_acc_nxt;
    acc_r       <= acc_nxt;
    nid_r       <= nid_nxt;
    zero_r      <= zero_nxt;
    paused_r    <= paused_nxt;
    mask_r      <= mask_nxt;
  end

  assign busy           = busy_r;
  assign out_strobe     = strobe_r;
  assign out_accepted   = acc_r;
  assign out_new_id     = nid_r;
  assign out_count_zero = zero_r;
  assign out_is_paused  = paused_r;
  assign out_fired_mask = mask_r;

endmodule

`default_nettype wire

// ----- design/stb_checker.sv -----
// ----------------------------------------------------------------------------
// stb_port_checks: port-level checks for the timer bank
// watches the request and result ports over time, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module stb_port_checks (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [stb_pkg::FUNC_W-1:0]  in_func,
  input wire logic                        out_strobe,
  input wire logic                        out_accepted,
  input wire logic [stb_pkg::ID_W-1:0]    out_new_id,
  input wire logic                        out_count_zero,
  input wire logic                        out_is_paused,
  input wire logic [stb_pkg::MASK_W-1:0]  out_fired_mask
);
  import stb_pkg::*;

  // a command other than tick answers in the next cycle
  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func != FN_TICK)) |=> out_strobe)
    else $error("command result missing");

  // a tick holds off new requests while it sweeps
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FN_TICK)) |=> (busy && !out_strobe))
    else $error("tick did not raise busy");

  // end of a sweep delivers the tick result
  a_sweep_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_strobe && out_accepted))
    else $error("tick result missing at end of sweep");

  // a rejected request carries all-zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_accepted) |->
      ((out_new_id == '0) && !out_count_zero && !out_is_paused &&
       (out_fired_mask == '0)))
    else $error("rejected request with nonzero fields");

endmodule

bind software_timer_bank_top stb_port_checks u_stb_port_checks (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_func        (in_func),
  .out_strobe     (out_strobe),
  .out_accepted   (out_accepted),
  .out_new_id     (out_new_id),
  .out_count_zero (out_count_zero),
  .out_is_paused  (out_is_paused),
  .out_fired_mask (out_fired_mask)
);

`default_nettype wire

// ----- dv/stb_checker.sv -----
// ----------------------------------------------------------------------------
// stb_checker: response checker for the timer bank
// watches the request and result channels, keeps its own copy of the timer
// state, predicts each response and compares it field by field
// ----------------------------------------------------------------------------
module stb_checker #(
  parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [stb_pkg::FUNC_W-1:0] in_func,
  input  logic [stb_pkg::ID_W-1:0]   in_timer_id,
  input  logic [31:0]                in_period_ticks,
  input  logic                       in_timer_mode,
  input  logic                       in_notify_enable,
  input  logic                       out_strobe,
  input  logic                       out_accepted,
  input  logic [stb_pkg::ID_W-1:0]   out_new_id,
  input  logic                       out_count_zero,
  input  logic                       out_is_paused,
  input  logic [stb_pkg::MASK_W-1:0] out_fired_mask,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import stb_pkg::*;

  typedef struct packed {
    logic              accepted;
    logic [ID_W-1:0]   new_id;
    logic              count_zero;
    logic              is_paused;
    logic [MASK_W-1:0] fired_mask;
  } timer_resp_t;

  // shadow timer state
  logic [31:0] reload_val [NUM_TIMERS];
  logic [31:0] count_val  [NUM_TIMERS];
  logic        periodic   [NUM_TIMERS];
  logic        running    [NUM_TIMERS];
  logic        expired    [NUM_TIMERS];
  logic        notify_on  [NUM_TIMERS];
  int          alloc_cnt;

  timer_resp_t resp_q [$];
  int          err_cnt = 0;

  assign fail_count = err_cnt;
  initial pending = 0;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h want %0h", $realtime, field, got, want);
    err_cnt++;
  endtask

  function automatic void clear_timers();
    for (int t = 0; t < NUM_TIMERS; t++) begin
      reload_val[t] = '0;
      count_val[t]  = '0;
      periodic[t]   = 1'b0;
      running[t]    = 1'b0;
      expired[t]    = 1'b0;
      notify_on[t]  = 1'b0;
    end
    alloc_cnt = 1;
  endfunction

  // applies one request to the shadow state and returns its response
  function automatic timer_resp_t predict_response(input logic [FUNC_W-1:0] fn,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [31:0] per,
                                                   input logic md,
                                                   input logic nt);
    timer_resp_t r;
    logic        known;
    logic        user;
    r     = '0;
    known = (int'(id) < alloc_cnt) && (int'(id) < NUM_TIMERS);
    user  = known && (id != '0);
    case (fn)
      FN_TICK: begin
        r.accepted = 1'b1;
        for (int t = 0; t < alloc_cnt && t < NUM_TIMERS; t++) begin
          if (running[t] && !expired[t] && count_val[t] != 0) begin
            count_val[t] = count_val[t] - 1;
            if (count_val[t] == 0) begin
              if (notify_on[t] && t < MASK_W) r.fired_mask[t] = 1'b1;
              expired[t] = 1'b1;
              if (!periodic[t]) running[t] = 1'b0;
            end
          end else if (running[t] && expired[t] && periodic[t]) begin
            count_val[t] = reload_val[t];
            expired[t]   = 1'b0;
          end
        end
      end
      FN_ALLOC: begin
        if (alloc_cnt < NUM_TIMERS) begin
          r.new_id   = alloc_cnt[ID_W-1:0];
          r.accepted = 1'b1;
          alloc_cnt++;
        end
      end
      FN_START: begin
        if (known) begin
          reload_val[id] = per;
          count_val[id]  = per;
          periodic[id]   = md;
          notify_on[id]  = nt;
          running[id]    = 1'b1;
          expired[id]    = 1'b0;
          r.accepted     = 1'b1;
        end
      end
      FN_STOP: begin
        if (user) begin
          running[id] = 1'b0;
          r.accepted  = 1'b1;
        end
      end
      FN_RESUME: begin
        if (user) begin
          running[id] = 1'b1;
          r.accepted  = 1'b1;
        end
      end
      FN_RESET: begin
        if (user) begin
          count_val[id] = reload_val[id];
          expired[id]   = 1'b0;
          running[id]   = 1'b1;
          r.accepted    = 1'b1;
        end
      end
      FN_QUERY: begin
        if (known) begin
          r.count_zero = (count_val[id] == 0);
          r.is_paused  = !running[id];
          r.accepted   = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    timer_resp_t want;
    if (!rst_n) begin
      clear_timers();
      resp_q.delete();
    end else begin
      // compare first: a result never belongs to a request taken at the same edge
      if (out_strobe) begin
        if (resp_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_accepted), 32'd0);
        end else begin
          want = resp_q.pop_front();
          if (out_accepted !== want.accepted)
            report_mismatch("accepted", 32'(out_accepted), 32'(want.accepted));
          if (out_new_id !== want.new_id)
            report_mismatch("new_id", 32'(out_new_id), 32'(want.new_id));
          if (out_count_zero !== want.count_zero)
            report_mismatch("count_zero", 32'(out_count_zero), 32'(want.count_zero));
          if (out_is_paused !== want.is_paused)
            report_mismatch("is_paused", 32'(out_is_paused), 32'(want.is_paused));
          if (out_fired_mask !== want.fired_mask)
            report_mismatch("fired_mask", out_fired_mask, want.fired_mask);
        end
      end
      if (start && !busy)
        resp_q.push_back(predict_response(in_func, in_timer_id, in_period_ticks,
                                          in_timer_mode, in_notify_enable));
    end
    pending <= resp_q.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the software timer bank
// drives directed and random command requests with random sender gaps;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stb_pkg::*;

  localparam int NUM_TIMERS = NUM_TIMERS_DEF;
  localparam int N_RANDOM   = 1400;
  localparam int CYCLE_CAP  = 400000;
  // func code with no command behind it
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              start            = 1'b0;
  logic              busy;
  logic [FUNC_W-1:0] in_func          = FN_TICK;
  logic [ID_W-1:0]   in_timer_id      = '0;
  logic [31:0]       in_period_ticks  = '0;
  logic              in_timer_mode    = 1'b0;
  logic              in_notify_enable = 1'b0;
  logic              out_strobe;
  logic              out_accepted;
  logic [ID_W-1:0]   out_new_id;
  logic              out_count_zero;
  logic              out_is_paused;
  logic [MASK_W-1:0] out_fired_mask;
  int                fail_count;
  int                pending;
  int                cycle_cnt = 0;
  // ids handed out so far, not counting the reserved id zero
  int                ids_out   = 0;

  software_timer_bank_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_timer_id      (in_timer_id),
    .in_period_ticks  (in_period_ticks),
    .in_timer_mode    (in_timer_mode),
    .in_notify_enable (in_notify_enable),
    .out_strobe       (out_strobe),
    .out_accepted     (out_accepted),
    .out_new_id       (out_new_id),
    .out_count_zero   (out_count_zero),
    .out_is_paused    (out_is_paused),
    .out_fired_mask   (out_fired_mask)
  );

  stb_checker #(.NUM_TIMERS(NUM_TIMERS)) u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_timer_id      (in_timer_id),
    .in_period_ticks  (in_period_ticks),
    .in_timer_mode    (in_timer_mode),
    .in_notify_enable (in_notify_enable),
    .out_strobe       (out_strobe),
    .out_accepted     (out_accepted),
    .out_new_id       (out_new_id),
    .out_count_zero   (out_count_zero),
    .out_is_paused    (out_is_paused),
    .out_fired_mask   (out_fired_mask),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // present one request and hold it until the block takes it
  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                              input logic [31:0] per, input logic md, input logic nt);
    start            <= 1'b1;
    in_func          <= fn;
    in_timer_id      <= id;
    in_period_ticks  <= per;
    in_timer_mode    <= md;
    in_notify_enable <= nt;
    // busy is sampled as it was at the edge, so this is the accept condition
    do @(posedge clk); while (busy);
    if (fn == FN_ALLOC && ids_out < NUM_TIMERS - 1) ids_out++;
  endtask

  // random gap on the sender side, taken with a pct percent chance
  task automatic sender_gap(input int pct);
    if (pct > 0 && $urandom_range(1, 100) <= pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // stop sending until every outstanding request has its result
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // mostly short periods so timers expire often, plus the extremes
  function automatic logic [31:0] pick_period();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 32'($urandom_range(1, 4));
    if (sel < 65) return 32'($urandom_range(5, 12));
    if (sel < 75) return 32'd0;
    if (sel < 82) return 32'hFFFF_FFFF - 32'($urandom_range(0, 1));
    return $urandom();
  endfunction

  // ids mostly among those handed out, sometimes anywhere
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 80) return ID_W'($urandom_range(0, ids_out));
    return ID_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 34) return FN_TICK;
    if (sel < 40) return FN_ALLOC;
    if (sel < 55) return FN_START;
    if (sel < 63) return FN_STOP;
    if (sel < 71) return FN_RESUME;
    if (sel < 79) return FN_RESET;
    if (sel < 97) return FN_QUERY;
    return FN_UNUSED;
  endfunction

  initial begin
    int idle_pct [4];
    int phase;
    idle_pct = '{0, 49, 0, 17};

    // synchronous reset, held low before the first requests
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // reserved id zero: query accepted, stop/resume/reset rejected
    send_request(FN_QUERY,  5'd0,  32'd0, 1'b0, 1'b0);
    send_request(FN_STOP,   5'd0,  32'd0, 1'b0, 1'b0);
    send_request(FN_RESUME, 5'd0,  32'd0, 1'b0, 1'b0);
    send_request(FN_RESET,  5'd0,  32'd0, 1'b0, 1'b0);
    // ids never handed out
    send_request(FN_QUERY,  5'd31, 32'd0, 1'b1, 1'b1);
    send_request(FN_START,  5'd3,  32'd7, 1'b1, 1'b1);
    // func code with no command
    send_request(FN_UNUSED, 5'd1,  32'hFFFF_FFFF, 1'b1, 1'b1);
    send_request(FN_TICK,   5'd0,  32'd0, 1'b0, 1'b0);
    send_request(FN_ALLOC,  5'd0,  32'd0, 1'b0, 1'b0);
    send_request(FN_ALLOC,  5'd0,  32'd0, 1'b0, 1'b0);
    send_request(FN_ALLOC,  5'd0,  32'd0, 1'b0, 1'b0);
    // one-shot with notify, periodic with notify, zero period, max period on id zero
    send_request(FN_START,  5'd1,  32'd1, 1'b0, 1'b1);
    send_request(FN_START,  5'd2,  32'd2, 1'b1, 1'b1);
    send_request(FN_START,  5'd3,  32'd0, 1'b1, 1'b1);
    send_request(FN_START,  5'd0,  32'hFFFF_FFFF, 1'b1, 1'b0);
    send_request(FN_TICK,   5'd0,  32'd0, 1'b0, 1'b0);
    send_request(FN_TICK,   5'd0,  32'd0, 1'b0, 1'b0);
    send_request(FN_TICK,   5'd0,  32'd0, 1'b0, 1'b0);
    send_request(FN_QUERY,  5'd1,  32'd0, 1'b0, 1'b0);
    send_request(FN_QUERY,  5'd3,  32'd0, 1'b0, 1'b0);
    send_request(FN_STOP,   5'd2,  32'd0, 1'b0, 1'b0);
    send_request(FN_QUERY,  5'd2,  32'd0, 1'b0, 1'b0);
    send_request(FN_RESUME, 5'd2,  32'd0, 1'b0, 1'b0);
    send_request(FN_RESET,  5'd1,  32'd0, 1'b0, 1'b0);
    send_request(FN_TICK,   5'd0,  32'd0, 1'b0, 1'b0);

    // ---- random part ----
    // four idling phases; the bank fills up along the way, so allocate
    // later also runs into the full case
    for (int i = 0; i < N_RANDOM; i++) begin
      phase = (i * 4) / N_RANDOM;
      // pressure point: let everything come back before carrying on
      if (i == N_RANDOM / 2) drain_results();
      sender_gap(idle_pct[phase]);
      send_request(pick_func(), pick_id(), pick_period(), 1'($urandom()), 1'($urandom()));
    end

    // wait for the last results, then idle with no requests before the verdict
    drain_results();
    repeat (NUM_TIMERS + 4) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- software_timer_bank_top.f -----
design/stb_pkg.sv
design/stb_cell.sv
design/software_timer_bank_top.sv
design/stb_checker.sv
dv/stb_checker.sv
dv/tb_top.sv
